// ===== src/pcq_pkg.sv =====
// Shared types and constants for the per-channel linear quantizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package pcq_pkg;

  localparam int MaxChannels = 1024;
  localparam int ChW = $clog2(MaxChannels);
  localparam int IdxStages = 32;   // bits of element_index
  localparam int QuoStages = 34;   // bits of the rounded quotient numerator

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    CFG_UNSIGNED_OUTPUT = 3'd0,
    CFG_BY_CHANNEL = 3'd1,
    CFG_SHARED_ZERO_POINT = 3'd2,
    CFG_CHANNEL_COUNT = 3'd3,
    CFG_SPATIAL_SIZE = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic kind;
    logic [9:0] load_channel;
    logic [31:0] load_scale;
    logic signed [8:0] load_zero_point;
    logic signed [31:0] sample;
    logic [31:0] element_index;
  } item_t;

  typedef struct packed {
    logic unsigned_output;
    logic by_channel;
    logic shared_zero_point;
    logic [10:0] channel_count;
    logic [24:0] spatial_size;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/pcq_chsel.sv =====
// Channel select pipeline: (element_index / spatial_size) mod channel_count,
// one quotient or remainder bit per stage. Depends on pcq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcq_chsel import pcq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic en,
  input wire logic in_vld,
  input wire item_t in_item,
  input wire cfg_t cfg,
  output logic out_vld,
  output item_t out_item,
  output logic [ChW-1:0] out_ch
);

  logic [24:0] ss;
  logic [10:0] cc;

  logic d_vld [IdxStages];
  item_t d_item [IdxStages];
  logic [24:0] d_rem [IdxStages];
  logic [31:0] d_quo [IdxStages];

  logic m_vld [IdxStages];
  item_t m_item [IdxStages];
  logic [10:0] m_rem [IdxStages];
  logic [31:0] m_quo [IdxStages];

  // zero sizes act as one
  assign ss = (cfg.spatial_size == '0) ? 25'd1 : cfg.spatial_size;
  assign cc = (cfg.channel_count == '0) ? 11'd1 : cfg.channel_count;

  for (genvar k = 0; k < IdxStages; k++) begin : g_div
    logic v_in;
    item_t it_in;
    logic [24:0] rem_in;
    logic [31:0] quo_in;
    logic [25:0] trial;
    if (k == 0) begin : g_first
      assign v_in = in_vld;
      assign it_in = in_item;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in = d_vld[k-1];
      assign it_in = d_item[k-1];
      assign rem_in = d_rem[k-1];
      assign quo_in = d_quo[k-1];
    end
    assign trial = {rem_in, it_in.element_index[IdxStages-1-k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[k] <= 1'b0;
      end else if (en) begin
        d_vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_item[k] <= it_in;
        if (trial >= {1'b0, ss}) begin
          d_rem[k] <= 25'(trial - {1'b0, ss});
          d_quo[k] <= {quo_in[30:0], 1'b1};
        end else begin
          d_rem[k] <= trial[24:0];
          d_quo[k] <= {quo_in[30:0], 1'b0};
        end
      end
    end
  end

  for (genvar k = 0; k < IdxStages; k++) begin : g_mod
    logic v_in;
    item_t it_in;
    logic [10:0] rem_in;
    logic [31:0] quo_in;
    logic [11:0] trial;
    if (k == 0) begin : g_first
      assign v_in = d_vld[IdxStages-1];
      assign it_in = d_item[IdxStages-1];
      assign rem_in = '0;
      assign quo_in = d_quo[IdxStages-1];
    end else begin : g_next
      assign v_in = m_vld[k-1];
      assign it_in = m_item[k-1];
      assign rem_in = m_rem[k-1];
      assign quo_in = m_quo[k-1];
    end
    assign trial = {rem_in, quo_in[IdxStages-1-k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        m_vld[k] <= 1'b0;
      end else if (en) begin
        m_vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_item[k] <= it_in;
        m_quo[k] <= quo_in;
        if (trial >= {1'b0, cc}) begin
          m_rem[k] <= 11'(trial - {1'b0, cc});
        end else begin
          m_rem[k] <= trial[10:0];
        end
      end
    end
  end

  assign out_vld = m_vld[IdxStages-1];
  assign out_item = m_item[IdxStages-1];
  // channel wraps at the table depth
  assign out_ch = cfg.by_channel ? m_rem[IdxStages-1][ChW-1:0] : '0;

endmodule
`default_nettype wire

// ===== src/pcq_tbl.sv =====
// Scale and zero point tables: one write and one registered read per cycle
// each while en is high. Depends on pcq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcq_tbl import pcq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic en,
  input wire logic in_vld,
  input wire item_t in_item,
  input wire logic [ChW-1:0] in_ch,
  input wire logic shared_zero_point,
  output logic out_vld,
  output item_t out_item,
  output logic [31:0] out_scale,
  output logic signed [8:0] out_zp
);

  logic [31:0] scale_mem [MaxChannels];
  logic signed [8:0] zp_mem [MaxChannels];
  logic [ChW-1:0] zaddr;

  assign zaddr = shared_zero_point ? '0 : in_ch;

  // loads and samples pass in order, so a read always sees earlier loads
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_vld && in_item.kind == KIND_LOAD) begin
        scale_mem[in_item.load_channel] <= in_item.load_scale;
        zp_mem[in_item.load_channel] <= in_item.load_zero_point;
      end
      out_scale <= scale_mem[in_ch];
      out_zp <= zp_mem[zaddr];
      out_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

endmodule
`default_nettype wire

// ===== src/pcq_quant.sv =====
// Quantize pipeline: rounded divide of |sample| by scale, one quotient bit
// per stage, then sign, zero point and clamp. Depends on pcq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcq_quant import pcq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic en,
  input wire logic in_vld,
  input wire item_t in_item,
  input wire logic [31:0] in_scale,
  input wire logic signed [8:0] in_zp,
  input wire logic unsigned_output,
  output logic out_valid,
  output logic signed [8:0] quantized,
  output logic [31:0] index_out
);

  logic [31:0] mag;

  logic p_vld;
  logic p_neg;
  logic p_zs;
  logic signed [8:0] p_zp;
  logic [31:0] p_idx;
  logic [33:0] p_num;
  logic [32:0] p_den;

  logic q_vld [QuoStages];
  logic q_neg [QuoStages];
  logic q_zs [QuoStages];
  logic signed [8:0] q_zp [QuoStages];
  logic [31:0] q_idx [QuoStages];
  logic [33:0] q_num [QuoStages];
  logic [32:0] q_den [QuoStages];
  logic [32:0] q_rem [QuoStages];
  logic [33:0] q_quo [QuoStages];

  logic signed [35:0] v;
  logic signed [35:0] q;
  logic signed [35:0] lo;
  logic signed [35:0] hi;
  logic signed [35:0] clamped;

  assign mag = in_item.sample[31] ? 32'(-in_item.sample) : 32'(in_item.sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_vld && (in_item.kind == KIND_SAMPLE);
    end
  end

  // round half away from zero: (2|s| + scale) / (2 scale)
  always_ff @(posedge clk) begin
    if (en) begin
      p_neg <= in_item.sample[31];
      p_zs <= (in_scale == '0);
      p_zp <= in_zp;
      p_idx <= in_item.element_index;
      p_num <= {1'b0, mag, 1'b0} + {2'b00, in_scale};
      p_den <= {in_scale, 1'b0};
    end
  end

  for (genvar k = 0; k < QuoStages; k++) begin : g_div
    logic v_in;
    logic neg_in;
    logic zs_in;
    logic signed [8:0] zp_in;
    logic [31:0] idx_in;
    logic [33:0] num_in;
    logic [32:0] den_in;
    logic [32:0] rem_in;
    logic [33:0] quo_in;
    logic [33:0] trial;
    if (k == 0) begin : g_first
      assign v_in = p_vld;
      assign neg_in = p_neg;
      assign zs_in = p_zs;
      assign zp_in = p_zp;
      assign idx_in = p_idx;
      assign num_in = p_num;
      assign den_in = p_den;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in = q_vld[k-1];
      assign neg_in = q_neg[k-1];
      assign zs_in = q_zs[k-1];
      assign zp_in = q_zp[k-1];
      assign idx_in = q_idx[k-1];
      assign num_in = q_num[k-1];
      assign den_in = q_den[k-1];
      assign rem_in = q_rem[k-1];
      assign quo_in = q_quo[k-1];
    end
    assign trial = {rem_in, num_in[QuoStages-1-k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        q_vld[k] <= 1'b0;
      end else if (en) begin
        q_vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_neg[k] <= neg_in;
        q_zs[k] <= zs_in;
        q_zp[k] <= zp_in;
        q_idx[k] <= idx_in;
        q_num[k] <= num_in;
        q_den[k] <= den_in;
        if (trial >= {1'b0, den_in}) begin
          q_rem[k] <= 33'(trial - {1'b0, den_in});
          q_quo[k] <= {quo_in[32:0], 1'b1};
        end else begin
          q_rem[k] <= trial[32:0];
          q_quo[k] <= {quo_in[32:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    lo = unsigned_output ? 36'sd0 : -36'sd128;
    hi = unsigned_output ? 36'sd255 : 36'sd127;
    v = q_neg[QuoStages-1] ? -$signed({2'b00, q_quo[QuoStages-1]})
                           : $signed({2'b00, q_quo[QuoStages-1]});
    q = v + 36'(q_zp[QuoStages-1]);
    if (q_zs[QuoStages-1]) begin
      // zero scale saturates by the sign of the sample
      clamped = q_neg[QuoStages-1] ? lo : hi;
    end else if (q < lo) begin
      clamped = lo;
    end else if (q > hi) begin
      clamped = hi;
    end else begin
      clamped = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_vld[QuoStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quantized <= clamped[8:0];
      index_out <= q_idx[QuoStages-1];
    end
  end

endmodule
`default_nettype wire

// ===== src/per_channel_linear_quantizer_unit.sv =====
// Top level of the per-channel linear quantizer: config registers, stall
// control and the chsel / tbl / quant pipeline. Depends on pcq_pkg.
//
//  channel  handshake               word
//  in       in_valid / in_stall     kind, load_channel, load_scale,
//                                   load_zero_point, sample, element_index
//  out      out_valid / out_stall   quantized, index_out
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word is accepted per cycle while in_stall is low; every sample gives one
// result through 64 stages of channel divide and modulo, 1 table read, 1 setup
// and 34 stages of rounded divide, 1 output register.
// Load words write the tables in order with samples and give no result.
// A stalled output holds the whole pipeline; reset clears the valid bits and
// sets the config registers to their defaults, the tables stay unwritten.
`timescale 1ns / 1ps
`default_nettype none
module per_channel_linear_quantizer_unit import pcq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic kind,
  input wire logic [9:0] load_channel,
  input wire logic [31:0] load_scale,
  input wire logic signed [8:0] load_zero_point,
  input wire logic signed [31:0] sample,
  input wire logic [31:0] element_index,
  output logic out_valid,
  input wire logic out_stall,
  output logic signed [8:0] quantized,
  output logic [31:0] index_out,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [2:0] cfg_index,
  input wire logic [24:0] cfg_data
);

  cfg_t cfg;
  logic en;
  item_t in_item;

  logic c_vld;
  item_t c_item;
  logic [ChW-1:0] c_ch;

  logic t_vld;
  item_t t_item;
  logic [31:0] t_scale;
  logic signed [8:0] t_zp;

  assign cfg_ready = 1'b1;
  // advance whenever the output word is free or being taken
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  assign in_item = '{kind: kind, load_channel: load_channel, load_scale: load_scale,
                     load_zero_point: load_zero_point, sample: sample,
                     element_index: element_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unsigned_output <= 1'b0;
      cfg.by_channel <= 1'b0;
      cfg.shared_zero_point <= 1'b1;
      cfg.channel_count <= 11'd1;
      cfg.spatial_size <= 25'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_UNSIGNED_OUTPUT: cfg.unsigned_output <= cfg_data[0];
        CFG_BY_CHANNEL: cfg.by_channel <= cfg_data[0];
        CFG_SHARED_ZERO_POINT: cfg.shared_zero_point <= cfg_data[0];
        CFG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[10:0];
        CFG_SPATIAL_SIZE: cfg.spatial_size <= cfg_data;
        default: ;
      endcase
    end
  end

  pcq_chsel u_chsel (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_vld(in_valid),
    .in_item(in_item),
    .cfg(cfg),
    .out_vld(c_vld),
    .out_item(c_item),
    .out_ch(c_ch)
  );

  pcq_tbl u_tbl (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_vld(c_vld),
    .in_item(c_item),
    .in_ch(c_ch),
    .shared_zero_point(cfg.shared_zero_point),
    .out_vld(t_vld),
    .out_item(t_item),
    .out_scale(t_scale),
    .out_zp(t_zp)
  );

  pcq_quant u_quant (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_vld(t_vld),
    .in_item(t_item),
    .in_scale(t_scale),
    .in_zp(t_zp),
    .unsigned_output(cfg.unsigned_output),
    .out_valid(out_valid),
    .quantized(quantized),
    .index_out(index_out)
  );

endmodule
`default_nettype wire
